>>> src/sadc_pkg.sv
`default_nettype none

package sadc_pkg;

    // Field widths of one sample and one result
    localparam int AXIS_N      = 6;
    localparam int AXIS_W      = 16;
    localparam int CLEAN_W     = 18;
    localparam int MODE_W      = 3;
    localparam int COUNT_W     = 16;
    localparam int IDX_W       = 3;

    // Packed stream widths, padded to whole bytes
    localparam int IN_FIELDS_W  = AXIS_N * AXIS_W + 2;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = AXIS_N * CLEAN_W + 1 + 1 + MODE_W + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Bit positions of the scalar fields
    localparam int IN_LEFT_BIT    = AXIS_N * AXIS_W;
    localparam int IN_RIGHT_BIT   = AXIS_N * AXIS_W + 1;
    localparam int OUT_BELOW_BIT  = AXIS_N * CLEAN_W;
    localparam int OUT_CAPT_BIT   = AXIS_N * CLEAN_W + 1;
    localparam int OUT_MODE_LSB   = AXIS_N * CLEAN_W + 2;
    localparam int OUT_CAL_BIT    = AXIS_N * CLEAN_W + 2 + MODE_W;

    // Arithmetic widths: a magnitude is at most 2^15, so a square fits 31 bits
    // and the sum of six squares fits 33 bits.
    localparam int PROD_W      = 31;
    localparam int SUM_W       = 33;
    localparam int FOUR_S_W    = SUM_W + 2;
    localparam int SIXTEEN_S_W = SUM_W + 4;
    localparam int RAD_W       = SIXTEEN_S_W + 1;
    localparam int ROOT_W      = RAD_W / 2;
    localparam int REM_W       = ROOT_W + 3;

    localparam logic [COUNT_W-1:0] CAL_SAMPLES_RST = 16'd100;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEARN,
        ST_SUM,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_APPLY,
        ST_DONE
    } sadc_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic             load;
        logic             learn;
        logic             clr_acc;
        logic             sq_en;
        logic             sq_noise;
        logic [IDX_W-1:0] sq_idx;
        logic             acc_en;
        logic             cmp_en;
        logic             root_start;
        logic             out_load;
    } sadc_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic cal;
        logic root_done;
        logic out_free;
    } sadc_sts_t;

endpackage

`default_nettype wire

>>> src/six_axis_deadband_calibrator.sv
// An accepted beat is latched; while it is used for learning, noise maxima are then
// summed as squares on one shared squarer and a bit-serial square root of the
// threshold is taken. Each axis is then squared and tested against the deadband.
// A new beat is accepted only once the previous result is in the output register.
// Reset (aresetn low at a clock edge): noise maxima, counters, button history and
// the output valid clear; mode returns to 3; calibration_samples returns to 100.
`default_nettype none

module six_axis_deadband_calibrator #(
    parameter int MODE_COUNT = 5,
    parameter int AXES       = 6
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // Configuration: calibration_samples
    input  wire logic                                   cfg_wr_en,
    input  wire logic [sadc_pkg::COUNT_W-1:0]           cfg_wr_data,
    // Sample stream
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // axis_0..axis_5 (16 bits each), button_left, button_right, zero padding
    input  wire logic [sadc_pkg::IN_TDATA_W-1:0]        s_tdata,
    // Result stream
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // clean_0..clean_5 (18 bits each), all_below, capture, mode (3 bits),
    // calibrating, zero padding
    output logic      [sadc_pkg::OUT_TDATA_W-1:0]       m_tdata
);

    sadc_pkg::sadc_cmd_t cmd;
    sadc_pkg::sadc_sts_t sts;

    // Sequencer
    sadc_ctrl #(
        .AXES (AXES)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Learning, threshold and deadband arithmetic
    sadc_dpath #(
        .AXES       (AXES),
        .MODE_COUNT (MODE_COUNT)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (s_tdata),
        .cmd         (cmd),
        .sts         (sts),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

`default_nettype wire

>>> src/sadc_isqrt.sv
`default_nettype none

module sadc_isqrt (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [sadc_pkg::RAD_W-1:0]   radicand,
    output logic      [sadc_pkg::ROOT_W-1:0]  root,
    output logic                              done
);

    localparam int STEP_W = $clog2(sadc_pkg::ROOT_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(sadc_pkg::ROOT_W - 1);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [STEP_W-1:0]             step_reg, step_next;
    logic [sadc_pkg::RAD_W-1:0]    rad_reg, rad_next;
    logic [sadc_pkg::REM_W-1:0]    rem_reg, rem_next;
    logic [sadc_pkg::ROOT_W-1:0]   root_reg, root_next;

    logic [sadc_pkg::REM_W-1:0]    rem_shift;
    logic [sadc_pkg::REM_W-1:0]    trial;

    // One result bit per cycle: bring down two radicand bits and try {root, 01}.
    assign rem_shift = {rem_reg[sadc_pkg::REM_W-3:0], rad_reg[sadc_pkg::RAD_W-1 -: 2]};
    assign trial     = sadc_pkg::REM_W'({root_reg, 2'b01});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            rad_next = {rad_reg[sadc_pkg::RAD_W-3:0], 2'b00};
            if (rem_shift >= trial) begin
                rem_next  = rem_shift - trial;
                root_next = {root_reg[sadc_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_shift;
                root_next = {root_reg[sadc_pkg::ROOT_W-2:0], 1'b0};
            end
            step_next = STEP_W'(step_reg + 1'b1);
            if (step_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state is reset; the arithmetic registers are not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root = root_reg;
    assign done = done_reg;

    // A new root is only started while the unit is free.
    a_start_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("square root started while busy");

endmodule

`default_nettype wire

>>> src/sadc_ctrl.sv
`default_nettype none

module sadc_ctrl #(
    parameter int AXES = 6
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    output sadc_pkg::sadc_cmd_t        cmd,
    input  wire sadc_pkg::sadc_sts_t   sts
);

    localparam int USED  = (AXES < sadc_pkg::AXIS_N) ? AXES : sadc_pkg::AXIS_N;
    localparam int CNT_W = $clog2(USED + 1);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(USED);

    sadc_pkg::sadc_state_t state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            sadc_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = sadc_pkg::ST_LEARN;
                end
            end
            sadc_pkg::ST_LEARN: begin
                cmd.learn = 1'b1;
                cnt_next  = '0;
                if (sts.cal) begin
                    cmd.clr_acc = 1'b1;
                    state_next  = sadc_pkg::ST_SUM;
                end else begin
                    state_next = sadc_pkg::ST_APPLY;
                end
            end
            sadc_pkg::ST_SUM: begin
                // Square noise maximum cnt while adding the previous square.
                cmd.sq_en    = (cnt_reg < CNT_END);
                cmd.sq_noise = 1'b1;
                cmd.sq_idx   = sadc_pkg::IDX_W'(cnt_reg);
                cmd.acc_en   = (cnt_reg != '0);
                cnt_next     = CNT_W'(cnt_reg + 1'b1);
                if (cnt_reg == CNT_END) begin
                    state_next = sadc_pkg::ST_ROOT_GO;
                end
            end
            sadc_pkg::ST_ROOT_GO: begin
                cmd.root_start = 1'b1;
                state_next     = sadc_pkg::ST_ROOT_WAIT;
            end
            sadc_pkg::ST_ROOT_WAIT: begin
                cnt_next = '0;
                if (sts.root_done) begin
                    state_next = sadc_pkg::ST_APPLY;
                end
            end
            sadc_pkg::ST_APPLY: begin
                // Square axis cnt while testing the previous axis.
                cmd.sq_en  = (cnt_reg < CNT_END);
                cmd.sq_idx = sadc_pkg::IDX_W'(cnt_reg);
                cmd.cmp_en = (cnt_reg != '0);
                cnt_next   = CNT_W'(cnt_reg + 1'b1);
                if (cnt_reg == CNT_END) begin
                    state_next = sadc_pkg::ST_DONE;
                end
            end
            sadc_pkg::ST_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = sadc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sadc_pkg::ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sadc_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> src/sadc_dpath.sv
`default_nettype none

module sadc_dpath #(
    parameter int AXES       = 6,
    parameter int MODE_COUNT = 5
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [sadc_pkg::COUNT_W-1:0]         cfg_wr_data,
    input  wire logic [sadc_pkg::IN_TDATA_W-1:0]      in_data,
    input  wire sadc_pkg::sadc_cmd_t                  cmd,
    output sadc_pkg::sadc_sts_t                       sts,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic      [sadc_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    localparam int USED = (AXES < sadc_pkg::AXIS_N) ? AXES : sadc_pkg::AXIS_N;
    localparam logic [sadc_pkg::MODE_W-1:0] MODE_RST =
        sadc_pkg::MODE_W'((3 < MODE_COUNT) ? 3 : 0);
    localparam logic [sadc_pkg::MODE_W:0] MODE_LIMIT = (sadc_pkg::MODE_W + 1)'(MODE_COUNT);

    // Latched sample
    logic [sadc_pkg::AXIS_W-1:0]   axis_reg [sadc_pkg::AXIS_N];
    logic                          left_reg;
    logic                          right_reg;
    logic [sadc_pkg::AXIS_W-1:0]   mag_in   [sadc_pkg::AXIS_N];

    // Learned state
    logic [sadc_pkg::AXIS_W-1:0]   noise_reg [sadc_pkg::AXIS_N];
    logic [sadc_pkg::COUNT_W-1:0]  counter_reg;
    logic [sadc_pkg::COUNT_W-1:0]  cal_samples_reg;
    logic [sadc_pkg::SUM_W-1:0]    acc_reg;
    logic [sadc_pkg::AXIS_W-1:0]   clip_reg;
    logic                          prev_left_reg;
    logic                          prev_right_reg;
    logic                          seen_reg;
    logic [sadc_pkg::MODE_W-1:0]   mode_reg;
    logic [sadc_pkg::MODE_W:0]     mode_step;

    // Squarer stage
    logic [sadc_pkg::AXIS_W-1:0]   sq_opd;
    logic [sadc_pkg::PROD_W-1:0]   prod_reg;
    logic [sadc_pkg::AXIS_W-1:0]   mag_reg;
    logic                          neg_reg;
    logic [sadc_pkg::IDX_W-1:0]    idx_reg;

    // Result being built
    logic [sadc_pkg::CLEAN_W-1:0]  clean_reg [sadc_pkg::AXIS_N];
    logic                          below_reg;
    logic                          capture_reg;
    logic                          cal_reg;
    logic                          cal_now;

    // Output register
    logic                               m_tvalid_reg;
    logic [sadc_pkg::OUT_TDATA_W-1:0]   m_tdata_reg;
    logic [sadc_pkg::OUT_TDATA_W-1:0]   out_word;

    // Square root
    logic [sadc_pkg::ROOT_W-1:0]   root;
    logic                          root_done;

    // Deadband test values
    logic [sadc_pkg::FOUR_S_W-1:0]    four_s;
    logic [sadc_pkg::SIXTEEN_S_W-1:0] sixteen_s;
    logic [sadc_pkg::AXIS_W-1:0]      pass_mag;
    logic [sadc_pkg::CLEAN_W-1:0]     pass_ext;

    // Magnitudes of the latched axes; the most negative sample gives 2^15.
    always_comb begin
        for (int i = 0; i < sadc_pkg::AXIS_N; i++) begin
            mag_in[i] = axis_reg[i][sadc_pkg::AXIS_W-1] ? (~axis_reg[i] + 1'b1) : axis_reg[i];
        end
    end

    assign cal_now   = (counter_reg < cal_samples_reg);
    assign mode_step = {1'b0, mode_reg} + 1'b1;

    assign sq_opd    = cmd.sq_noise ? noise_reg[cmd.sq_idx] : mag_in[cmd.sq_idx];
    assign four_s    = {acc_reg, 2'b00};
    assign sixteen_s = {acc_reg, 4'b0000};

    // Above the clip level the magnitude is replaced by floor(4*sqrt(S)).
    assign pass_mag = (sadc_pkg::SIXTEEN_S_W'(prod_reg) > sixteen_s) ? clip_reg : mag_reg;
    assign pass_ext = sadc_pkg::CLEAN_W'(pass_mag);

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_samples_reg <= sadc_pkg::CAL_SAMPLES_RST;
        end else if (cfg_wr_en) begin
            cal_samples_reg <= cfg_wr_data;
        end
    end

    // Sample latch
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            for (int i = 0; i < sadc_pkg::AXIS_N; i++) begin
                axis_reg[i] <= in_data[i*sadc_pkg::AXIS_W +: sadc_pkg::AXIS_W];
            end
            left_reg  <= in_data[sadc_pkg::IN_LEFT_BIT];
            right_reg <= in_data[sadc_pkg::IN_RIGHT_BIT];
        end
    end

    // Noise learning, button edges and mode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < sadc_pkg::AXIS_N; i++) begin
                noise_reg[i] <= '0;
            end
            counter_reg    <= '0;
            prev_left_reg  <= 1'b0;
            prev_right_reg <= 1'b0;
            seen_reg       <= 1'b0;
            mode_reg       <= MODE_RST;
            cal_reg        <= 1'b0;
            capture_reg    <= 1'b0;
        end else if (cmd.learn) begin
            cal_reg <= cal_now;
            if (cal_now) begin
                for (int i = 0; i < USED; i++) begin
                    if (mag_in[i] > noise_reg[i]) begin
                        noise_reg[i] <= mag_in[i];
                    end
                end
                counter_reg <= sadc_pkg::COUNT_W'(counter_reg + 1'b1);
            end
            capture_reg <= seen_reg && left_reg && !prev_left_reg;
            if (seen_reg && right_reg && !prev_right_reg) begin
                mode_reg <= (mode_step >= MODE_LIMIT) ? '0 : mode_step[sadc_pkg::MODE_W-1:0];
            end
            prev_left_reg  <= left_reg;
            prev_right_reg <= right_reg;
            seen_reg       <= 1'b1;
        end
    end

    // Sum of squares and the clip level derived from it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            clip_reg <= '0;
        end else begin
            if (cmd.clr_acc) begin
                acc_reg <= '0;
            end else if (cmd.acc_en) begin
                acc_reg <= acc_reg + sadc_pkg::SUM_W'(prod_reg);
            end
            // The clip level only matters when it is below a magnitude of 2^15.
            if (root_done) begin
                clip_reg <= root[sadc_pkg::AXIS_W-1:0];
            end
        end
    end

    // Shared squarer
    always_ff @(posedge aclk) begin
        if (cmd.sq_en) begin
            prod_reg <= sadc_pkg::PROD_W'(sq_opd * sq_opd);
            mag_reg  <= sq_opd;
            neg_reg  <= axis_reg[cmd.sq_idx][sadc_pkg::AXIS_W-1];
            idx_reg  <= cmd.sq_idx;
        end
    end

    // Deadband and clip, one axis a cycle
    always_ff @(posedge aclk) begin
        if (cmd.learn) begin
            for (int i = 0; i < sadc_pkg::AXIS_N; i++) begin
                clean_reg[i] <= '0;
            end
            below_reg <= 1'b1;
        end else if (cmd.cmp_en) begin
            if (sadc_pkg::FOUR_S_W'(prod_reg) > four_s) begin
                below_reg          <= 1'b0;
                clean_reg[idx_reg] <= neg_reg ? (~pass_ext + 1'b1) : pass_ext;
            end
        end
    end

    sadc_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.root_start),
        .radicand (sadc_pkg::RAD_W'(sixteen_s)),
        .root     (root),
        .done     (root_done)
    );

    // Pack the result beat
    always_comb begin
        out_word = '0;
        for (int i = 0; i < sadc_pkg::AXIS_N; i++) begin
            out_word[i*sadc_pkg::CLEAN_W +: sadc_pkg::CLEAN_W] = clean_reg[i];
        end
        out_word[sadc_pkg::OUT_BELOW_BIT]                     = below_reg;
        out_word[sadc_pkg::OUT_CAPT_BIT]                      = capture_reg;
        out_word[sadc_pkg::OUT_MODE_LSB +: sadc_pkg::MODE_W]  = mode_reg;
        out_word[sadc_pkg::OUT_CAL_BIT]                       = cal_reg;
    end

    // Output register: holds a beat until it is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            m_tdata_reg <= out_word;
        end
    end

    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;
    assign sts.cal       = cal_now;
    assign sts.root_done = root_done;
    assign sts.out_free  = !m_tvalid_reg || m_tready;

    a_mode_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (mode_reg < MODE_LIMIT[sadc_pkg::MODE_W-1:0]) || (MODE_COUNT == 8))
        else $error("mode outside its range");

    a_counter_on_learn: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (counter_reg != $past(counter_reg))) |-> $past(cmd.learn))
        else $error("sample counter moved outside a learning step");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result beat overwritten before it was taken");

endmodule

`default_nettype wire

>>> tb/six_axis_deadband_checker.sv
`default_nettype none

module six_axis_deadband_checker #(
    parameter int MODE_COUNT = 5,
    parameter int AXES       = 6
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [sadc_pkg::COUNT_W-1:0]      cfg_wr_data,
    input  wire logic                              s_tvalid,
    input  wire logic                              s_tready,
    // axis_0..axis_5 (16 bits each), button_left, button_right, zero padding
    input  wire logic [sadc_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    // clean_0..clean_5 (18 bits each), all_below, capture, mode (3 bits),
    // calibrating, zero padding
    input  wire logic [sadc_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output int                                     fail_count,
    output int                                     outstanding
);

    import sadc_pkg::*;

    localparam int LIVE_AXES = (AXES < AXIS_N) ? AXES : AXIS_N;
    localparam logic [MODE_W-1:0] MODE_AFTER_RESET = (3 < MODE_COUNT) ? MODE_W'(3) : '0;

    typedef struct packed {
        logic [AXIS_N-1:0][CLEAN_W-1:0] clean;
        logic                           all_below;
        logic                           capture;
        logic [MODE_W-1:0]              mode;
        logic                           calibrating;
    } clean_sample_t;

    // Shadow copy of the calibrator state
    logic [AXIS_W-1:0]  noise_peak [AXIS_N];
    logic [COUNT_W-1:0] learned_count;
    logic [COUNT_W-1:0] cal_limit;
    logic [MODE_W-1:0]  mode_now;
    logic               last_left;
    logic               last_right;
    logic               seen_any;

    // Cleaned samples still to come out of the block, oldest first
    clean_sample_t predicted_samples [$];

    initial begin
        fail_count  = 0;
        outstanding = 0;
    end

    // Floor of the square root, one result bit per pair of radicand bits.
    function automatic longint unsigned root_floor(input longint unsigned radicand);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned probe;
        rem   = radicand;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > rem)
            probe >>= 2;
        while (probe != 0) begin
            if (rem >= root + probe) begin
                rem  -= root + probe;
                root  = (root >> 1) + probe;
            end else begin
                root >>= 1;
            end
            probe >>= 2;
        end
        return root;
    endfunction

    // Learns noise from one sample if still calibrating, then applies the
    // deadband and clip and tracks the button edges.
    task automatic calibrate_and_clean(input logic [IN_TDATA_W-1:0] beat,
                                       output clean_sample_t res);
        logic signed [AXIS_W:0] val [AXIS_N];
        longint unsigned        mag [AXIS_N];
        longint unsigned        sum_sq;
        longint unsigned        clip_mag;
        longint unsigned        sq;
        longint unsigned        kept;
        logic                   learning;
        logic                   left;
        logic                   right;
        int                     next_mode;

        for (int i = 0; i < AXIS_N; i++) begin
            val[i] = $signed(beat[i*AXIS_W +: AXIS_W]);
            mag[i] = (val[i] < 0) ? 64'(-val[i]) : 64'(val[i]);
        end

        // Noise learning only while the count is below the register
        learning = (learned_count < cal_limit);
        if (learning) begin
            for (int i = 0; i < LIVE_AXES; i++)
                if (mag[i] > 64'(noise_peak[i]))
                    noise_peak[i] = mag[i][AXIS_W-1:0];
            learned_count = learned_count + 1'b1;
        end

        sum_sq = 0;
        for (int i = 0; i < LIVE_AXES; i++)
            sum_sq += 64'(noise_peak[i]) * 64'(noise_peak[i]);
        clip_mag = root_floor(16 * sum_sq);

        // Exact deadband test on squares; clip keeps the sign
        res             = '0;
        res.all_below   = 1'b1;
        res.calibrating = learning;
        for (int i = 0; i < LIVE_AXES; i++) begin
            sq = mag[i] * mag[i];
            if (sq > 4 * sum_sq) begin
                res.all_below = 1'b0;
                kept = mag[i];
                if (sq > 16 * sum_sq && clip_mag < kept)
                    kept = clip_mag;
                res.clean[i] = (val[i] < 0) ? CLEAN_W'(64'd0 - kept) : CLEAN_W'(kept);
            end
        end

        // Button edges; the first sample after reset never counts
        left  = beat[IN_LEFT_BIT];
        right = beat[IN_RIGHT_BIT];
        res.capture = seen_any && left && !last_left;
        if (seen_any && right && !last_right) begin
            next_mode = int'(mode_now) + 1;
            mode_now  = (next_mode >= MODE_COUNT) ? '0 : MODE_W'(next_mode);
        end
        last_left  = left;
        last_right = right;
        seen_any   = 1'b1;
        res.mode   = mode_now;
    endtask

    // Watch both channels and the register port at every rising edge.
    always @(posedge aclk) begin : watch
        clean_sample_t want;
        clean_sample_t got;
        if (!aresetn) begin
            for (int i = 0; i < AXIS_N; i++)
                noise_peak[i] = '0;
            learned_count = '0;
            cal_limit     = CAL_SAMPLES_RST;
            mode_now      = MODE_AFTER_RESET;
            last_left     = 1'b0;
            last_right    = 1'b0;
            seen_any      = 1'b0;
            predicted_samples.delete();
        end else begin
            // Result beat against the oldest prediction
            if (m_tvalid && m_tready) begin
                for (int i = 0; i < AXIS_N; i++)
                    got.clean[i] = m_tdata[i*CLEAN_W +: CLEAN_W];
                got.all_below   = m_tdata[OUT_BELOW_BIT];
                got.capture     = m_tdata[OUT_CAPT_BIT];
                got.mode        = m_tdata[OUT_MODE_LSB +: MODE_W];
                got.calibrating = m_tdata[OUT_CAL_BIT];
                if (predicted_samples.size() == 0) begin
                    $error("result beat with no prediction waiting");
                    fail_count++;
                end else begin
                    want = predicted_samples.pop_front();
                    for (int i = 0; i < AXIS_N; i++)
                        if (got.clean[i] !== want.clean[i]) begin
                            $error("clean_%0d mismatch: expected %0d, actual %0d", i,
                                   $signed(want.clean[i]), $signed(got.clean[i]));
                            fail_count++;
                        end
                    if (got.all_below !== want.all_below) begin
                        $error("all_below mismatch: expected %0d, actual %0d",
                               want.all_below, got.all_below);
                        fail_count++;
                    end
                    if (got.capture !== want.capture) begin
                        $error("capture mismatch: expected %0d, actual %0d",
                               want.capture, got.capture);
                        fail_count++;
                    end
                    if (got.mode !== want.mode) begin
                        $error("mode mismatch: expected %0d, actual %0d",
                               want.mode, got.mode);
                        fail_count++;
                    end
                    if (got.calibrating !== want.calibrating) begin
                        $error("calibrating mismatch: expected %0d, actual %0d",
                               want.calibrating, got.calibrating);
                        fail_count++;
                    end
                end
            end

            if (cfg_wr_en)
                cal_limit = cfg_wr_data;

            // Each accepted sample beat yields exactly one cleaned sample
            if (s_tvalid && s_tready) begin
                calibrate_and_clean(s_tdata, want);
                predicted_samples.push_back(want);
            end
        end
        outstanding = predicted_samples.size();
    end

endmodule

`default_nettype wire

>>> tb/six_axis_deadband_calibrator_tb.sv
`default_nettype none

module six_axis_deadband_calibrator_tb;

    import sadc_pkg::*;

    localparam int MODE_COUNT    = 5;
    localparam int AXES          = 6;
    // Longest time from a sample beat to its result, while learning
    localparam int SETTLE_CYCLES = 2 * AXES + 26;
    localparam int STALL_LIMIT   = 4000;

    typedef logic [AXIS_N-1:0][AXIS_W-1:0] axis_set_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [COUNT_W-1:0]     cfg_wr_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int fail_count;
    int pending_results;
    int send_idle_pct;
    int recv_idle_pct = 66;
    int quiet_cycles  = 0;

    // Button pattern for the directed samples; starts with both pressed
    logic [7:0] directed_seq = 8'd3;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    six_axis_deadband_calibrator #(
        .MODE_COUNT(MODE_COUNT),
        .AXES      (AXES)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    six_axis_deadband_checker #(
        .MODE_COUNT(MODE_COUNT),
        .AXES      (AXES)
    ) result_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .outstanding(pending_results)
    );

    // The receiver stalls at random, one decision per cycle.
    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Give up when neither channel has moved a beat for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("six_axis_deadband_calibrator_tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic axis_set_t axes6(input int a0, input int a1, input int a2,
                                        input int a3, input int a4, input int a5);
        axis_set_t set;
        set[0] = AXIS_W'(a0);
        set[1] = AXIS_W'(a1);
        set[2] = AXIS_W'(a2);
        set[3] = AXIS_W'(a3);
        set[4] = AXIS_W'(a4);
        set[5] = AXIS_W'(a5);
        return set;
    endfunction

    function automatic logic [AXIS_W-1:0] rand_within(input int span);
        return AXIS_W'($urandom_range(2 * span) - span);
    endfunction

    // Mostly values around the threshold, with full-range values,
    // extremes and exact zeros mixed in.
    function automatic logic [AXIS_W-1:0] rand_signal(input int span);
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return rand_within(span);
            5, 6:          return AXIS_W'($urandom);
            7: begin
                case ($urandom_range(4))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'h0001;
                    3:       return 16'hFFFF;
                    default: return 16'h0000;
                endcase
            end
            default:       return '0;
        endcase
    endfunction

    // Drive one sample beat and hold it until the block takes it.
    task automatic send_sample(input axis_set_t ax, input logic left, input logic right);
        logic [IN_TDATA_W-1:0] beat;
        beat = '0;
        for (int i = 0; i < AXIS_N; i++)
            beat[i*AXIS_W +: AXIS_W] = ax[i];
        beat[IN_LEFT_BIT]  = left;
        beat[IN_RIGHT_BIT] = right;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        do
            @(posedge aclk);
        while (!s_tready);
    endtask

    task automatic send_directed(input axis_set_t ax);
        send_sample(ax, directed_seq[1], directed_seq[0]);
        directed_seq++;
    endtask

    // Quiet noise for the learning window
    task automatic send_noise(input int count, input int amp);
        axis_set_t ax;
        repeat (count) begin
            for (int i = 0; i < AXIS_N; i++)
                ax[i] = rand_within(amp);
            send_sample(ax, 1'($urandom_range(1)), 1'($urandom_range(1)));
        end
    endtask

    task automatic send_motion(input int count, input int span);
        axis_set_t ax;
        repeat (count) begin
            for (int i = 0; i < AXIS_N; i++)
                ax[i] = rand_signal(span);
            send_sample(ax, 1'($urandom_range(1)), 1'($urandom_range(1)));
        end
    endtask

    // Stop sending and wait until every predicted result has come out.
    task automatic wait_for_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results != 0)
            @(negedge aclk);
    endtask

    task automatic write_cal_samples(input int count);
        wait_for_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= COUNT_W'(count);
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        send_idle_pct = 30;
        recv_idle_pct = 66;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // No learning at all: only exact zeros fall inside the deadband.
        write_cal_samples(0);
        send_directed(axes6(0, 0, 0, 0, 0, 0));
        send_directed(axes6(32767, -32768, 1, -1, 0, 0));
        send_directed(axes6(0, 0, 0, 0, 0, -32768));
        send_directed(axes6(0, 0, 0, 0, 0, 0));

        // Learn a threshold that is not a whole root, then probe the
        // exact deadband edge and the rounded-down clip.
        write_cal_samples(3);
        send_directed(axes6(1, -1, 0, 0, 0, 0));
        send_directed(axes6(0, 0, 0, 0, 0, 0));
        send_directed(axes6(-1, 1, 0, 0, 0, 0));
        send_directed(axes6(2, -2, 0, 0, 0, 0));
        send_directed(axes6(3, -3, 2, 0, 0, 0));
        send_directed(axes6(5, -5, 6, -6, 0, 0));
        send_directed(axes6(32767, -32768, 0, 0, 0, 7));

        // Raising the register resumes learning.
        write_cal_samples(5);
        send_directed(axes6(3, 4, 0, 0, 0, 0));
        send_directed(axes6(0, 0, 0, 0, 0, 0));
        send_directed(axes6(10, -10, 11, -11, 0, 0));
        send_directed(axes6(20, -20, 21, -21, 0, 0));
        send_directed(axes6(-32768, 32767, 0, 0, 0, 0));

        // Lowering it below the count stops learning.
        write_cal_samples(2);
        send_directed(axes6(-32768, -32768, -32768, -32768, -32768, -32768));
        send_directed(axes6(32767, 32767, 32767, 32767, 32767, 32767));
        send_directed(axes6(9, 10, 11, -9, -10, -11));

        // Short learning window, then motion around a small threshold;
        // the sender also drains the block once midway.
        write_cal_samples(40);
        send_noise(35, 300);
        send_motion(230, 4000);
        wait_for_results();
        send_motion(235, 4000);

        // Learning with the register at its largest value, then none.
        send_idle_pct = 66;
        recv_idle_pct = 30;
        write_cal_samples(65535);
        send_noise(150, 3000);
        write_cal_samples(0);
        send_motion(350, 20000);

        // Back-to-back traffic with a brief extra learning window.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_cal_samples(195);
        send_noise(5, 100);
        send_motion(545, 20000);

        // The most negative sample learnt as noise.
        write_cal_samples(65535);
        send_directed(axes6(-32768, 0, 0, 0, 0, 0));
        send_directed(axes6(32767, -32768, 32767, -32768, 1, -1));
        send_directed(axes6(0, 0, 0, 0, 0, 0));

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_results == 0) begin
            $display("six_axis_deadband_calibrator_tb: PASS");
        end else begin
            $display("six_axis_deadband_calibrator_tb: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
src/sadc_pkg.sv
src/sadc_isqrt.sv
src/sadc_ctrl.sv
src/sadc_dpath.sv
src/six_axis_deadband_calibrator.sv
tb/six_axis_deadband_checker.sv
tb/six_axis_deadband_calibrator_tb.sv
